>>> sv/text_line_and_word_pattern_filter_assert.svh
// assertion macros for the text line and word pattern filter checker
// depends on nothing; taken in by the checker file
`ifndef TEXT_LINE_AND_WORD_PATTERN_FILTER_ASSERT_SVH
`define TEXT_LINE_AND_WORD_PATTERN_FILTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TLWF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlwf check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define TLWF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlwf check failed: next-cycle implication");

`endif

>>> sv/tlwf_pkg.sv
// shared types, character codes and register indexes of the pattern filter
// depends on nothing
package tlwf_pkg;

   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PIECE_LEN_W = 9;
   localparam int PAT_WORD_BYTES = 8;
   // the last pattern register only carries two bytes
   localparam int PAT3_BYTES  = 2;

   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MODE   = 3'd0,
      REG_LENGTH = 3'd1,
      REG_PAT0   = 3'd2,
      REG_PAT1   = 3'd3,
      REG_PAT2   = 3'd4,
      REG_PAT3   = 3'd5
   } reg_index_type;

   // mode register values
   localparam logic MODE_LINE = 1'b0;
   localparam logic MODE_WORD = 1'b1;

   typedef struct packed {
      logic mode;
      logic clear;
   } ctrl_type;

   typedef struct packed {
      logic                   matched;
      logic [PIECE_LEN_W-1:0] length;
   } result_type;

   function automatic logic is_line_end(input logic [BYTE_W-1:0] c);
      return (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

   function automatic logic is_word_end(input logic [BYTE_W-1:0] c);
      return (c == CHAR_LF) || (c == CHAR_CR) || (c == CHAR_TAB) || (c == CHAR_SPACE);
   endfunction

endpackage

>>> sv/tlwf_csr.sv
// configuration registers: mode, pattern length and pattern bytes
// depends on tlwf_pkg
module tlwf_csr #(
   parameter int MAX_PATTERN = 30,
   localparam int LW = $clog2(MAX_PATTERN + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [tlwf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tlwf_pkg::CSR_DATA_W-1:0]     csr_data,
   output tlwf_pkg::ctrl_type                  ctrl,
   output logic [LW-1:0]                       eff_len,
   output logic [MAX_PATTERN*tlwf_pkg::BYTE_W-1:0] pattern
);

   localparam int PW = MAX_PATTERN * tlwf_pkg::BYTE_W;

   logic          mode_ff, mode_in;
   logic [4:0]    len_ff, len_in;
   logic [PW-1:0] pat_ff, pat_in;
   logic [5:0]    len_ext;

   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      pat_in  = pat_ff;
      if (csr_valid) begin
         if (csr_index == tlwf_pkg::REG_MODE) begin
            mode_in = csr_data[0];
         end
         if (csr_index == tlwf_pkg::REG_LENGTH) begin
            len_in = csr_data[4:0];
         end
      end
      for (int j = 0; j < MAX_PATTERN; j++) begin
         // byte j lives in pattern register j/8, lane j%8
         if (csr_valid && (int'(csr_index) == int'(tlwf_pkg::REG_PAT0) + j / 8) &&
             (j < 3 * tlwf_pkg::PAT_WORD_BYTES + tlwf_pkg::PAT3_BYTES)) begin
            pat_in[j*tlwf_pkg::BYTE_W +: tlwf_pkg::BYTE_W] =
               csr_data[(j % 8)*tlwf_pkg::BYTE_W +: tlwf_pkg::BYTE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tlwf_pkg::MODE_LINE;
         len_ff  <= 5'd1;
         pat_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         pat_ff  <= pat_in;
      end
   end

   // zero counts as one, oversize clamps to the pattern store
   always_comb begin
      len_ext = {1'b0, len_ff};
      if (len_ff == 5'd0) begin
         eff_len = LW'(1);
      end else if (int'(len_ext) > MAX_PATTERN) begin
         eff_len = LW'(MAX_PATTERN);
      end else begin
         eff_len = LW'(len_ext);
      end
   end

   assign ctrl.mode  = mode_ff;
   assign ctrl.clear = csr_valid && (csr_index <= tlwf_pkg::REG_PAT3);
   assign pattern    = pat_ff;

endmodule

>>> sv/tlwf_match.sv
// piece state and per-byte match logic for line and word modes
// depends on tlwf_pkg
module tlwf_match #(
   parameter int MAX_PATTERN = 30,
   parameter int MAX_LINE    = 256,
   localparam int LW = $clog2(MAX_PATTERN + 1)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step,
   input  logic [tlwf_pkg::BYTE_W-1:0]             text_byte,
   input  tlwf_pkg::ctrl_type                      ctrl,
   input  logic [LW-1:0]                           eff_len,
   input  logic [MAX_PATTERN*tlwf_pkg::BYTE_W-1:0] pattern,
   output logic                                    res_valid,
   output tlwf_pkg::result_type                    result
);

   localparam int MAXC = (MAX_LINE > MAX_PATTERN) ? MAX_LINE : MAX_PATTERN;
   localparam int CW   = $clog2(MAXC + 1);
   localparam int SW   = ((CW > LW) ? CW : LW) + 1;
   localparam int OW   = CW + tlwf_pkg::PIECE_LEN_W;

   logic [MAX_PATTERN-1:0] pv_ff, pv_in, cmask, pv_new;
   logic                   hit_ff, hit_in, top_hit;
   logic [CW-1:0]          cnt_ff, cnt_in, cnt_inc, len_src;
   logic [LW-1:0]          idx_ff, idx_in, idx_new;
   logic [tlwf_pkg::BYTE_W-1:0] pat_sel;
   logic                   idx_step, word_hit_end, word_hit_full;
   logic [SW-1:0]          m_s, m1_s;
   logic [OW-1:0]          len_wide;

   always_comb begin
      cnt_inc = cnt_ff + 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         cmask[i] = (i < int'(eff_len)) &&
                    (pattern[i*tlwf_pkg::BYTE_W +: tlwf_pkg::BYTE_W] == text_byte);
      end
      pv_new  = ((pv_ff << 1) | MAX_PATTERN'(1)) & cmask;
      top_hit = 1'b0;
      pat_sel = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (i == int'(eff_len) - 1) begin
            top_hit = pv_new[i];
         end
         if (i == int'(idx_ff)) begin
            pat_sel = pattern[i*tlwf_pkg::BYTE_W +: tlwf_pkg::BYTE_W];
         end
      end
      idx_step = (idx_ff < eff_len) && (pat_sel == text_byte);
      idx_new  = idx_ff + LW'(idx_step);
      m_s      = SW'(eff_len);
      m1_s     = m_s + 1'b1;
      word_hit_end  = (idx_ff == eff_len) &&
                      ((SW'(cnt_ff) == m_s) || (SW'(cnt_ff) == m1_s));
      word_hit_full = (idx_new == eff_len) &&
                      ((SW'(cnt_inc) == m_s) || (SW'(cnt_inc) == m1_s));
   end

   always_comb begin
      pv_in          = pv_ff;
      hit_in         = hit_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      res_valid      = 1'b0;
      result.matched = 1'b0;
      len_src        = cnt_ff;
      if (step) begin
         if (ctrl.mode == tlwf_pkg::MODE_LINE) begin
            if (tlwf_pkg::is_line_end(text_byte)) begin
               res_valid      = 1'b1;
               result.matched = hit_ff;
               len_src        = cnt_ff;
               pv_in  = '0;
               hit_in = 1'b0;
               cnt_in = '0;
               idx_in = '0;
            end else begin
               pv_in  = pv_new;
               hit_in = hit_ff | top_hit;
               cnt_in = cnt_inc;
               if (int'(cnt_inc) >= MAX_LINE) begin
                  res_valid      = 1'b1;
                  result.matched = hit_ff | top_hit;
                  len_src        = cnt_inc;
                  pv_in  = '0;
                  hit_in = 1'b0;
                  cnt_in = '0;
                  idx_in = '0;
               end
            end
         end else begin
            if (tlwf_pkg::is_word_end(text_byte)) begin
               res_valid      = 1'b1;
               result.matched = word_hit_end;
               len_src        = cnt_ff;
               pv_in  = '0;
               hit_in = 1'b0;
               cnt_in = '0;
               idx_in = '0;
            end else begin
               idx_in = idx_new;
               cnt_in = cnt_inc;
               if (int'(cnt_inc) >= MAX_PATTERN) begin
                  res_valid      = 1'b1;
                  result.matched = word_hit_full;
                  len_src        = cnt_inc;
                  pv_in  = '0;
                  hit_in = 1'b0;
                  cnt_in = '0;
                  idx_in = '0;
               end
            end
         end
      end
      if (ctrl.clear) begin
         pv_in  = '0;
         hit_in = 1'b0;
         cnt_in = '0;
         idx_in = '0;
      end
      len_wide      = OW'(len_src);
      result.length = len_wide[tlwf_pkg::PIECE_LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff  <= '0;
         hit_ff <= 1'b0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         pv_ff  <= pv_in;
         hit_ff <= hit_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

endmodule

>>> sv/text_line_and_word_pattern_filter.sv
// top level of the text line and word pattern filter
// depends on tlwf_pkg, tlwf_csr and tlwf_match
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_text_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_piece_matched, rsp_piece_length
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// one byte per cycle sustained while no result is held; a byte waits in the input register
// and its result, if any, is registered into the output register when the byte steps
// piece state update (shift-and vector, hit flag, word index, count) is a single registered loop
// reset clears control and piece state; mode 0, length 1, pattern bytes zero
// a held result stalls the input register, which still takes one more byte
module text_line_and_word_pattern_filter #(
   parameter int MAX_PATTERN = 30,
   parameter int MAX_LINE    = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tlwf_pkg::BYTE_W-1:0]      req_text_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_piece_matched,
   output logic [tlwf_pkg::PIECE_LEN_W-1:0] rsp_piece_length,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tlwf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tlwf_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int LW = $clog2(MAX_PATTERN + 1);

   // input register
   logic                        in_valid_ff, in_valid_in;
   logic [tlwf_pkg::BYTE_W-1:0] in_byte_ff, in_byte_in;
   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   tlwf_pkg::result_type        rsp_res_ff, rsp_res_in;

   logic                        advance, step, req_take, res_valid;
   tlwf_pkg::ctrl_type          ctrl;
   logic [LW-1:0]               eff_len;
   logic [MAX_PATTERN*tlwf_pkg::BYTE_W-1:0] pattern;
   tlwf_pkg::result_type        result;

   // output slot free or emptied this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   tlwf_csr #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctrl      (ctrl),
      .eff_len   (eff_len),
      .pattern   (pattern)
   );

   tlwf_match #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_LINE    (MAX_LINE)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .text_byte (in_byte_ff),
      .ctrl      (ctrl),
      .eff_len   (eff_len),
      .pattern   (pattern),
      .res_valid (res_valid),
      .result    (result)
   );

   always_comb begin
      // input register holds its byte while stalled
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
      end else begin
         in_valid_in = in_valid_ff && !step;
         in_byte_in  = in_byte_ff;
      end
      // output register loads only when the slot moves on
      if (advance) begin
         rsp_valid_in = res_valid;
         rsp_res_in   = res_valid ? result : rsp_res_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
         rsp_res_in   = rsp_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_piece_matched = rsp_res_ff.matched;
   assign rsp_piece_length  = rsp_res_ff.length;

endmodule

>>> sv/tlwf_checker.sv
// port-level checks for the pattern filter, bound to the top level
// depends on tlwf_pkg and text_line_and_word_pattern_filter_assert.svh
`include "text_line_and_word_pattern_filter_assert.svh"

module tlwf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_piece_matched,
   input logic [tlwf_pkg::PIECE_LEN_W-1:0] rsp_piece_length
);

   // a held result keeps its payload
   `TLWF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_piece_matched) && $stable(rsp_piece_length))

   // with the output slot empty the input never stalls
   `TLWF_ASSERT_NOW(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // an empty piece can never match
   `TLWF_ASSERT_NOW(a_empty_no_match, clock, reset, rsp_valid && (rsp_piece_length == '0), !rsp_piece_matched)

endmodule

bind text_line_and_word_pattern_filter tlwf_checker u_tlwf_checker (.*);
